// ===== sv/clipped_glyph_pixel_expander_top_defines.svh =====
// Assertion macros for the clipped glyph pixel expander.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef CLIPPED_GLYPH_PIXEL_EXPANDER_TOP_DEFINES_SVH
`define CLIPPED_GLYPH_PIXEL_EXPANDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked at every clock edge outside reset.
`define CGPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CGPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CGPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CGPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/cgpe_pkg.sv =====
// Shared sizes, register indexes and channel types of the glyph pixel expander.
// No dependencies; imported by every module of the block.
package cgpe_pkg;

  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 8;
  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 192;

  localparam int PIX_ALL   = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int PIX_TOTAL = (PIX_ALL > 64) ? 64 : PIX_ALL;
  localparam int ROWS_USED = (PIX_TOTAL + GLYPH_WIDTH - 1) / GLYPH_WIDTH;
  localparam int COL_W     = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

  localparam int ADDR_W  = 16;
  localparam int COLOR_W = 24;
  localparam int CLIP_W  = 8;
  // 16-bit position times 8 plus a column offset, compared against 256 or 192
  localparam int POS_W   = 24;

  localparam logic [ADDR_W-1:0] ADDR_ROW_STEP = ADDR_W'(FRAME_WIDTH - GLYPH_WIDTH + 1);

  // Two-entry queues between the parts
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  typedef struct packed {
    logic [63:0]         glyph_bits;
    logic signed [15:0]  place_x;
    logic signed [15:0]  place_y;
    logic [COLOR_W-1:0]  fore_color;
    logic [COLOR_W-1:0]  back_color;
    logic                grid_mode;
    logic                hide_back;
  } glyph_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_write;
  } pixel_wr_t;

  typedef struct packed {
    logic [CLIP_W-1:0] left;
    logic [CLIP_W-1:0] top;
    logic [CLIP_W-1:0] right;
    logic [CLIP_W-1:0] bottom;
  } clip_t;

  // One classified glyph: which pixels survive, their pattern bits, start address
  typedef struct packed {
    logic [PIX_TOTAL-1:0] keep;
    logic [PIX_TOTAL-1:0] set;
    logic [ADDR_W-1:0]    base;
    logic [COLOR_W-1:0]   fore;
    logic [COLOR_W-1:0]   back;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ===== sv/cgpe_front.sv =====
// Front part: accepts glyph items, works out per-pixel visibility and the
// start address, and holds them in a two-entry command queue. Uses cgpe_pkg.
module cgpe_front import cgpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  clip_t      clip_i,
  input  glyph_req_t req_i,
  input  logic       push,
  output logic       full,
  output cmd_chan_t  cmd_o,
  input  logic       cmd_pop_i
);

  logic signed [POS_W-1:0] x_ext, y_ext, x_org, y_org;
  logic signed [POS_W-1:0] clip_l, clip_t_s, clip_r, clip_b;
  logic signed [POS_W-1:0] col_pos [GLYPH_WIDTH];
  logic signed [POS_W-1:0] row_pos [ROWS_USED];
  logic [GLYPH_WIDTH-1:0]  col_ok;
  logic [ROWS_USED-1:0]    row_ok;
  cmd_t                    cmd_new;

  cmd_t                    ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]      wr_q, rd_q;
  logic [Q_CNT_W-1:0]      cnt_q, cnt_d;
  logic                    do_push, do_pop;

  always_comb begin
    x_ext = POS_W'(req_i.place_x);
    y_ext = POS_W'(req_i.place_y);
    x_org = req_i.grid_mode ? POS_W'(x_ext * GLYPH_WIDTH) : x_ext;
    y_org = req_i.grid_mode ? POS_W'(y_ext * GLYPH_HEIGHT) : y_ext;
    clip_l   = signed'(POS_W'(clip_i.left));
    clip_t_s = signed'(POS_W'(clip_i.top));
    clip_r   = signed'(POS_W'(clip_i.right));
    clip_b   = signed'(POS_W'(clip_i.bottom));
    // Clip bounds are never negative, so the low clip test also drops negatives
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      col_pos[c] = x_org + POS_W'(c);
      col_ok[c]  = (col_pos[c] >= clip_l) && (col_pos[c] <= clip_r) &&
                   (col_pos[c] < POS_W'(FRAME_WIDTH));
    end
    for (int r = 0; r < ROWS_USED; r++) begin
      row_pos[r] = y_org + POS_W'(r);
      row_ok[r]  = (row_pos[r] >= clip_t_s) && (row_pos[r] <= clip_b) &&
                   (row_pos[r] < POS_W'(FRAME_HEIGHT));
    end
    for (int i = 0; i < PIX_TOTAL; i++) begin
      cmd_new.keep[i] = col_ok[i % GLYPH_WIDTH] && row_ok[i / GLYPH_WIDTH] &&
                        (req_i.glyph_bits[i] || !req_i.hide_back);
    end
    cmd_new.set  = req_i.glyph_bits[PIX_TOTAL-1:0];
    // Address arithmetic wraps at 16 bits, so a negative origin still adds up
    cmd_new.base = ADDR_W'(y_org * FRAME_WIDTH + x_org);
    cmd_new.fore = req_i.fore_color;
    cmd_new.back = req_i.back_color;
  end

  assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop_i && (cnt_q != '0);
  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/cgpe_back.sv =====
// Back part: walks one classified glyph a pixel per cycle while the result queue
// has room and queues the framebuffer writes in a two-entry result queue. Uses cgpe_pkg.
module cgpe_back import cgpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_chan_t cmd_i,
  output logic      cmd_pop_o,
  output logic      busy_o,
  output logic      empty,
  input  logic      pop,
  output pixel_wr_t pixel_o
);

  logic                 busy_q;
  logic [PIX_TOTAL-1:0] keep_q, set_q, rest;
  logic [ADDR_W-1:0]    addr_q;
  logic [COL_W-1:0]     col_q;
  logic [COLOR_W-1:0]   fore_q, back_q;
  logic                 step, done, load, emit, res_full;
  pixel_wr_t            res_new;

  pixel_wr_t            ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_pop;

  assign res_full = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign step     = busy_q && !res_full;
  assign rest     = keep_q >> 1;
  // Stop as soon as no surviving pixel is left in the glyph
  assign done     = step && (rest == '0);
  assign load     = cmd_i.valid && (!busy_q || done);
  assign emit     = step && keep_q[0];

  assign cmd_pop_o = load;
  assign busy_o    = busy_q;

  assign res_new.pixel_address = addr_q;
  assign res_new.pixel_color   = set_q[0] ? fore_q : back_q;
  assign res_new.last_write    = (rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      keep_q <= cmd_i.cmd.keep;
      set_q  <= cmd_i.cmd.set;
      addr_q <= cmd_i.cmd.base;
      fore_q <= cmd_i.cmd.fore;
      back_q <= cmd_i.cmd.back;
      col_q  <= '0;
    end else if (step) begin
      keep_q <= rest;
      set_q  <= set_q >> 1;
      if (col_q == COL_W'(GLYPH_WIDTH - 1)) begin
        addr_q <= addr_q + ADDR_ROW_STEP;
        col_q  <= '0;
      end else begin
        addr_q <= addr_q + 1'b1;
        col_q  <= col_q + 1'b1;
      end
    end
  end

  // Result queue
  assign empty   = (cnt_q == '0);
  assign do_pop  = pop && !empty;
  assign pixel_o = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (emit && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !emit) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (emit) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ent_q[wr_q] <= res_new;
    end
  end

endmodule

// ===== sv/clipped_glyph_pixel_expander_top.sv =====
// Top level of the clipped glyph pixel expander: clip registers, front and
// back parts. Uses cgpe_pkg, cgpe_front, cgpe_back and the assertion macros.
//
// Use: push a glyph item (64 pattern bits, position, colors, grid and
// hide-background flags) on glyph_i while full is low. Each visible pixel
// comes out as one framebuffer write on pixel_o, oldest first while empty
// is low; pop takes it. The last write of a glyph has last_write set, and a
// glyph with no visible pixel gives no write at all.
// Flow: an accepted item passes through the command queue and the walk
// registers of the back part into the result queue before it reaches
// pixel_o. The back part visits one pixel per cycle in scan order while
// the result queue has room and stops after the last visible one. A two-entry
// command queue lets the next glyph be accepted while one is expanded.
// When pop stays low the two-entry result queue fills and the pixel walk
// holds; the command queue then fills and full rises.
// Reset empties both queues and sets the clip rectangle to the whole
// 256 x 192 frame. Write clip registers through cfg_we_i only while idle.
`include "clipped_glyph_pixel_expander_top_defines.svh"

module clipped_glyph_pixel_expander_top import cgpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CLIP_W-1:0]    cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  glyph_req_t           glyph_i,
  output logic                 empty,
  input  logic                 pop,
  output pixel_wr_t            pixel_o
);

  clip_t     clip_q;
  cmd_chan_t cmd_chan;
  logic      cmd_pop;
  logic      back_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q.left   <= 8'd0;
      clip_q.top    <= 8'd0;
      clip_q.right  <= 8'd255;
      clip_q.bottom <= 8'd191;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_LEFT:   clip_q.left   <= cfg_data_i;
        REG_CLIP_TOP:    clip_q.top    <= cfg_data_i;
        REG_CLIP_RIGHT:  clip_q.right  <= cfg_data_i;
        REG_CLIP_BOTTOM: clip_q.bottom <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cgpe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clip_i    (clip_q),
    .req_i     (glyph_i),
    .push      (push),
    .full      (full),
    .cmd_o     (cmd_chan),
    .cmd_pop_i (cmd_pop)
  );

  cgpe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_chan),
    .cmd_pop_o (cmd_pop),
    .busy_o    (back_busy),
    .empty     (empty),
    .pop       (pop),
    .pixel_o   (pixel_o)
  );

  `CGPE_ASSERT(a_pop_needs_cmd, clk_i, rst_ni, !cmd_pop || cmd_chan.valid,
               "command popped from empty queue")
  `CGPE_ASSERT(a_full_has_cmd, clk_i, rst_ni, !full || cmd_chan.valid,
               "full while no command waits")
  `CGPE_ASSERT_NEXT(a_idle_no_result, clk_i, rst_ni,
                    !back_busy && !cmd_chan.valid && empty, empty,
                    "write appeared with no glyph in flight")

endmodule

// ===== test/tb_clipped_glyph_pixel_expander_top.sv =====
// Self-checking testbench for clipped_glyph_pixel_expander_top: glyph items are
// pushed with random gaps, framebuffer writes are popped with random stalls and
// checked in order against a local predictor. Depends on cgpe_pkg and the RTL.
module tb_clipped_glyph_pixel_expander_top;
  import cgpe_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  // Time for glyphs still queued or in expansion to finish, plus the pipeline
  localparam int SETTLE_CYCLES = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_CLIP_LEFT;
  logic [CLIP_W-1:0]    cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  glyph_req_t           glyph_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  pixel_wr_t            pixel_o;

  // Shadow of the clip window, reset values of the block
  logic [CLIP_W-1:0] win_left = 8'd0;
  logic [CLIP_W-1:0] win_top = 8'd0;
  logic [CLIP_W-1:0] win_right = 8'd255;
  logic [CLIP_W-1:0] win_bottom = 8'd191;

  glyph_req_t glyphs_todo[$];
  pixel_wr_t  pixels_due[$];
  pixel_wr_t  want;
  int         push_hold = 0;
  int         pop_hold = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  clipped_glyph_pixel_expander_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .glyph_i   (glyph_i),
    .empty     (empty),
    .pop       (pop),
    .pixel_o   (pixel_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; no gaps at all in one window out of four
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_count[10:9] == 2'd0) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Expected framebuffer writes of one glyph under the current clip window
  function automatic void expand_glyph(glyph_req_t g);
    int x0, y0, px, py, final_pix, i;
    logic [63:0] shown;
    pixel_wr_t wr;
    x0 = $signed(g.place_x);
    y0 = $signed(g.place_y);
    if (g.grid_mode) begin
      x0 = x0 * GLYPH_WIDTH;
      y0 = y0 * GLYPH_HEIGHT;
    end
    shown = '0;
    final_pix = -1;
    for (i = 0; i < PIX_TOTAL; i++) begin
      px = x0 + i % GLYPH_WIDTH;
      py = y0 + i / GLYPH_WIDTH;
      if ((g.glyph_bits[i] || !g.hide_back) &&
          px >= int'(win_left) && px <= int'(win_right) &&
          py >= int'(win_top) && py <= int'(win_bottom) &&
          px >= 0 && py >= 0 && px < FRAME_WIDTH && py < FRAME_HEIGHT) begin
        shown[i] = 1'b1;
        final_pix = i;
      end
    end
    for (i = 0; i < PIX_TOTAL; i++) begin
      if (shown[i]) begin
        px = x0 + i % GLYPH_WIDTH;
        py = y0 + i / GLYPH_WIDTH;
        wr.pixel_address = ADDR_W'(py * FRAME_WIDTH + px);
        wr.pixel_color = g.glyph_bits[i] ? g.fore_color : g.back_color;
        wr.last_write = (i == final_pix);
        pixels_due.push_back(wr);
      end
    end
  endfunction

  // Driver: hold the item until accepted, then predict and advance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expand_glyph(glyph_i);
        void'(glyphs_todo.pop_front());
        push_hold = pick_pause();
      end
      if (push_hold > 0) begin
        push_hold = push_hold - 1;
        push <= 1'b0;
      end else if (glyphs_todo.size() > 0) begin
        push <= 1'b1;
        glyph_i <= glyphs_todo[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped write with the oldest expected one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected write: expected none, got addr %0d color %06h last %0b",
                   $time, pixel_o.pixel_address, pixel_o.pixel_color,
                   pixel_o.last_write);
        end else begin
          want = pixels_due.pop_front();
          if (pixel_o.pixel_address !== want.pixel_address ||
              pixel_o.pixel_color !== want.pixel_color ||
              pixel_o.last_write !== want.last_write) begin
            mismatches++;
            $display("%0t: write mismatch: expected addr %0d color %06h last %0b, ",
                     $time, want.pixel_address, want.pixel_color, want.last_write,
                     "got addr %0d color %06h last %0b",
                     pixel_o.pixel_address, pixel_o.pixel_color, pixel_o.last_write);
          end
        end
        pop_hold = pick_pause();
      end
      if (pop_hold > 0) begin
        pop_hold = pop_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic glyph_req_t make_glyph(logic [63:0] bits, int x, int y,
                                            logic [23:0] fg, logic [23:0] bg,
                                            logic grid, logic hide);
    glyph_req_t g;
    g.glyph_bits = bits;
    g.place_x = 16'(x);
    g.place_y = 16'(y);
    g.fore_color = fg;
    g.back_color = bg;
    g.grid_mode = grid;
    g.hide_back = hide;
    return g;
  endfunction

  // Mostly glyphs near the frame, some with fully random positions
  function automatic glyph_req_t random_glyph();
    glyph_req_t g;
    int pick;
    g.glyph_bits = {$urandom(), $urandom()};
    pick = $urandom_range(0, 9);
    if (pick == 0) g.glyph_bits = '1;
    else if (pick == 1) g.glyph_bits = g.glyph_bits & {$urandom(), $urandom()};
    g.fore_color = 24'($urandom());
    g.back_color = 24'($urandom());
    g.grid_mode = 1'($urandom_range(0, 1));
    g.hide_back = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      g.place_x = 16'($urandom());
      g.place_y = 16'($urandom());
    end else if (g.grid_mode) begin
      g.place_x = 16'(int'($urandom_range(0, 35)) - 2);
      g.place_y = 16'(int'($urandom_range(0, 27)) - 2);
    end else begin
      g.place_x = 16'(int'($urandom_range(0, 271)) - 8);
      g.place_y = 16'(int'($urandom_range(0, 207)) - 8);
    end
    return g;
  endfunction

  task automatic queue_random(int n);
    repeat (n) glyphs_todo.push_back(random_glyph());
  endtask

  // Wait until every item is taken and every write seen, then let the block go idle
  task automatic drain();
    while (glyphs_todo.size() != 0 || pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_clip_window(logic [7:0] l, logic [7:0] t,
                                  logic [7:0] r, logic [7:0] b);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_CLIP_LEFT;
    cfg_data_i <= l;
    @(posedge clk_i);
    cfg_idx_i <= REG_CLIP_TOP;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_idx_i <= REG_CLIP_RIGHT;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i <= REG_CLIP_BOTTOM;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_left = l;
    win_top = t;
    win_right = r;
    win_bottom = b;
  endtask

  task automatic random_window();
    int l, t;
    l = $urandom_range(0, 255);
    t = $urandom_range(0, 191);
    load_clip_window(8'(l), 8'(t), 8'($urandom_range(l, 255)), 8'($urandom_range(t, 191)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset clip window (whole frame)
    glyphs_todo.push_back(make_glyph('1, 0, 0, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('0, 10, 10, 24'hFFFFFF, 24'h000000, 1'b0, 1'b1));
    glyphs_todo.push_back(make_glyph('0, 10, 10, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph(64'h55AA_55AA_55AA_55AA, 248, 184,
                                     24'h123456, 24'hEDCBA9, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph(64'h55AA_55AA_55AA_55AA, 252, 188,
                                     24'hA5A5A5, 24'h5A5A5A, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, -4, -4, 24'h00FF00, 24'h0000FF, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, -8, 0, 24'h00FF00, 24'h0000FF, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, 256, 0, 24'h00FF00, 24'h0000FF, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, 0, 192, 24'h00FF00, 24'h0000FF, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, 32767, 32767, 24'hFF0000, 24'h0, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, -32768, -32768, 24'hFF0000, 24'h0, 1'b0, 1'b0));
    glyphs_todo.push_back(make_glyph('1, 31, 23, 24'h808080, 24'h7F7F7F, 1'b1, 1'b0));
    glyphs_todo.push_back(make_glyph('1, 32, 0, 24'h808080, 24'h7F7F7F, 1'b1, 1'b0));
    glyphs_todo.push_back(make_glyph('1, -1, -1, 24'h808080, 24'h7F7F7F, 1'b1, 1'b0));
    glyphs_todo.push_back(make_glyph('1, -32768, 32767, 24'h808080, 24'h7F7F7F, 1'b1, 1'b0));
    glyphs_todo.push_back(make_glyph(64'h8000_0000_0000_0000, 100, 100,
                                     24'hFFFFFF, 24'h000000, 1'b0, 1'b1));
    glyphs_todo.push_back(make_glyph(64'h1, 0, 0, 24'hFFFFFF, 24'h000000, 1'b0, 1'b1));
    glyphs_todo.push_back(make_glyph(64'h8000_0000_0000_0000, 248, 184,
                                     24'hFFFFFF, 24'h000000, 1'b0, 1'b1));
    glyphs_todo.push_back(make_glyph(64'hF0F0_F0F0_F0F0_F0F0, 1, 1,
                                     24'h0F0F0F, 24'hF0F0F0, 1'b1, 1'b1));
    queue_random(10);
    drain();

    // Whole frame written explicitly, then a sequence of clip windows
    load_clip_window(8'd0, 8'd0, 8'd255, 8'd191);
    queue_random(15);
    drain();

    random_window();
    queue_random(15);
    drain();

    load_clip_window(8'd248, 8'd184, 8'd255, 8'd191);
    glyphs_todo.push_back(make_glyph('1, 250, 186, 24'hFFFF00, 24'h00FFFF, 1'b0, 1'b0));
    queue_random(10);
    drain();

    // Empty clip horizontally, then vertically
    load_clip_window(8'd200, 8'd0, 8'd10, 8'd191);
    glyphs_todo.push_back(make_glyph('1, 0, 0, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0));
    queue_random(6);
    drain();

    load_clip_window(8'd0, 8'd150, 8'd255, 8'd20);
    glyphs_todo.push_back(make_glyph('1, 100, 100, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0));
    queue_random(6);
    drain();

    random_window();
    queue_random(20);
    drain();

    load_clip_window(8'd0, 8'd0, 8'd0, 8'd0);
    glyphs_todo.push_back(make_glyph('1, -3, -3, 24'h010203, 24'h040506, 1'b0, 1'b0));
    queue_random(8);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
